>>> rtl/bps_pkg.sv
package bps_pkg;

    // Image and window dimensions are clamped to this bound
    localparam int MAX_DIM = 4096;
    localparam int DIM_W   = 13;
    localparam int COLOR_W = 24;
    // (w-1-c)*ww and (h-1-r)*wh stay below 2^24
    localparam int PROD_W  = 24;
    localparam int CFG_IDX_W = 3;
    localparam int BUDGET_W  = 33;

    typedef logic [DIM_W-1:0]   dim_t;
    typedef logic [COLOR_W-1:0] color_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BYTE_BUDGET   = 3'd5;

    localparam logic MODE_TILE  = 1'b0;
    localparam logic MODE_SCALE = 1'b1;

    localparam logic [BUDGET_W-1:0] BYTES_PER_PIXEL = 33'd3;

    typedef struct packed {
        logic        display_mode;
        dim_t        image_width;
        dim_t        image_height;
        dim_t        window_width;
        dim_t        window_height;
        logic [31:0] byte_budget;
    } bps_cfg_t;

    // Command passed from the byte front end to the rectangle back end
    typedef struct packed {
        logic   restart;   // new image: reset edges, start row 0
        logic   pixel;     // a complete pixel
        logic   tile;      // pixel is drawn one to one
        logic   row_adv;   // a row ends after this command
        dim_t   col;       // clamped column of the pixel
        dim_t   tile_y;    // window row of the pixel in tile mode
        dim_t   next_row;  // row to start
        color_t color;
        logic   spent;     // byte budget used up by this pixel
    } bps_cmd_t;

    // A zero dimension counts as one, anything above the bound as the bound
    function automatic dim_t clamp_dim(input dim_t v);
        dim_t r;
        if (v == '0)
        begin
            r = dim_t'(1);
        end
        else if (v > dim_t'(MAX_DIM))
        begin
            r = dim_t'(MAX_DIM);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

>>> rtl/bps_if.sv
// Byte input channel
interface bps_in_if import bps_pkg::*; ;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_byte;
    logic       start_of_image;

    modport source (output valid, output pixel_byte, output start_of_image, input ready);
    modport sink   (input valid, input pixel_byte, input start_of_image, output ready);
endinterface

// Fill rectangle output channel
interface bps_out_if import bps_pkg::*; ;
    logic   valid;
    logic   ready;
    dim_t   rect_left;
    dim_t   rect_top;
    dim_t   rect_right;
    dim_t   rect_bottom;
    color_t fill_color;
    logic   budget_exhausted;

    modport source (
        output valid, output rect_left, output rect_top, output rect_right,
        output rect_bottom, output fill_color, output budget_exhausted,
        input ready
    );
    modport sink (
        input valid, input rect_left, input rect_top, input rect_right,
        input rect_bottom, input fill_color, input budget_exhausted,
        output ready
    );
endinterface

>>> rtl/bps_front.sv
module bps_front import bps_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  bps_cfg_t cfg,
    bps_in_if.sink   in_ch,
    input  logic     q_full,
    output logic     push,
    output bps_cmd_t push_cmd
);

    localparam logic [1:0] PH_LOW  = 2'd0;
    localparam logic [1:0] PH_MID  = 2'd1;
    localparam logic [1:0] PH_HIGH = 2'd2;

    logic [1:0]          phase_reg, phase_next;
    logic [15:0]         part_reg, part_next;
    dim_t                col_reg, col_next;
    dim_t                row_reg, row_next;
    logic [1:0]          pad_reg, pad_next;
    logic [BUDGET_W-1:0] budget_reg, budget_next;
    logic                fin_reg, fin_next;

    dim_t                w, h, col_c, col_inc, row_inc;
    logic [BUDGET_W-1:0] budget_dec;
    logic                spent;
    logic                accept;

    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && !q_full;

    // Byte classification and counters
    always_comb
    begin
        w          = clamp_dim(cfg.image_width);
        h          = clamp_dim(cfg.image_height);
        col_c      = (col_reg < w) ? col_reg : w - dim_t'(1);
        col_inc    = col_reg + dim_t'(1);
        row_inc    = row_reg + dim_t'(1);
        budget_dec = budget_reg - BYTES_PER_PIXEL;
        spent      = budget_dec[BUDGET_W-1] || (budget_dec == '0);

        phase_next  = phase_reg;
        part_next   = part_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        pad_next    = pad_reg;
        budget_next = budget_reg;
        fin_next    = fin_reg;
        push        = 1'b0;
        push_cmd    = '0;

        if (accept)
        begin
            if (in_ch.start_of_image)
            begin
                // restart; this byte is the first of pixel 0
                phase_next       = PH_MID;
                part_next        = {8'h00, in_ch.pixel_byte};
                col_next         = '0;
                row_next         = '0;
                pad_next         = '0;
                budget_next      = {1'b0, cfg.byte_budget};
                fin_next         = 1'b0;
                push             = 1'b1;
                push_cmd.restart = 1'b1;
            end
            else if (fin_reg)
            begin
                // image done: bytes are dropped
            end
            else if (row_reg >= h)
            begin
                fin_next = 1'b1;
            end
            else if (pad_reg != '0)
            begin
                pad_next = pad_reg - 2'd1;
                if (pad_reg == 2'd1)
                begin
                    row_next = row_inc;
                    col_next = '0;
                    if (row_inc >= h)
                    begin
                        fin_next = 1'b1;
                    end
                    else
                    begin
                        push              = 1'b1;
                        push_cmd.row_adv  = 1'b1;
                        push_cmd.next_row = row_inc;
                    end
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_LOW:
                    begin
                        part_next  = {8'h00, in_ch.pixel_byte};
                        phase_next = PH_MID;
                    end
                    PH_MID:
                    begin
                        part_next  = {in_ch.pixel_byte, part_reg[7:0]};
                        phase_next = PH_HIGH;
                    end
                    default:
                    begin
                        phase_next      = PH_LOW;
                        push            = 1'b1;
                        push_cmd.pixel  = 1'b1;
                        push_cmd.col    = col_c;
                        push_cmd.tile_y = h - dim_t'(1) - row_reg;
                        push_cmd.color  = {in_ch.pixel_byte, part_reg};
                        push_cmd.tile   = (cfg.display_mode == MODE_TILE);
                        if ((cfg.display_mode == MODE_TILE) && spent)
                        begin
                            budget_next    = budget_dec;
                            push_cmd.spent = 1'b1;
                            fin_next       = 1'b1;
                        end
                        else
                        begin
                            if (cfg.display_mode == MODE_TILE)
                            begin
                                budget_next = budget_dec;
                            end
                            col_next = col_inc;
                            if (col_inc >= w)
                            begin
                                pad_next = w[1:0];
                                if (w[1:0] == 2'd0)
                                begin
                                    row_next = row_inc;
                                    col_next = '0;
                                    if (row_inc >= h)
                                    begin
                                        fin_next = 1'b1;
                                    end
                                    else
                                    begin
                                        push_cmd.row_adv  = 1'b1;
                                        push_cmd.next_row = row_inc;
                                    end
                                end
                            end
                        end
                    end
                endcase
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_LOW;
            part_reg   <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            pad_reg    <= '0;
            budget_reg <= {1'b0, 32'hffff_ffff};
            fin_reg    <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            part_reg   <= part_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            pad_reg    <= pad_next;
            budget_reg <= budget_next;
            fin_reg    <= fin_next;
        end
    end

endmodule

>>> rtl/bps_cmd_fifo.sv
module bps_cmd_fifo import bps_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  bps_cmd_t push_cmd,
    output logic     full,
    input  logic     pop,
    output bps_cmd_t pop_cmd,
    output logic     empty
);

    bps_cmd_t   entry_reg [0:1];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign pop_cmd = entry_reg[rd_ptr_reg];

    // Pointer and fill level update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> rtl/bps_divider.sv
module bps_divider import bps_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [PROD_W-1:0] dividend,
    input  dim_t              divisor,
    output logic              done,
    output dim_t              quotient
);

    // Quotient is known to fit DIM_W bits: one quotient bit per cycle
    localparam int         DIV_STEPS = DIM_W;
    localparam int         CNT_W     = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_STEPS - 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    dim_t             rem_reg, rem_next;
    dim_t             quo_reg, quo_next;
    dim_t             dsr_reg, dsr_next;
    logic [DIM_W:0]   trial;
    logic             ge;

    assign done     = done_reg;
    assign quotient = quo_reg;

    // Restoring shift and subtract step
    always_comb
    begin
        trial     = {rem_reg, quo_reg[DIM_W-1]};
        ge        = (trial >= {1'b0, dsr_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = DIM_W'(dividend >> DIM_W);
            quo_next  = dividend[DIM_W-1:0];
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? DIM_W'(trial - {1'b0, dsr_reg}) : DIM_W'(trial);
            quo_next = {quo_reg[DIM_W-2:0], ge};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

endmodule

>>> rtl/bps_back.sv
module bps_back import bps_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  bps_cfg_t cfg,
    input  logic     q_empty,
    input  bps_cmd_t q_cmd,
    output logic     pop,
    bps_out_if.source out_ch
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_START = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_PIX   = 3'd4;

    logic [2:0]        state_reg, state_next;
    bps_cmd_t          cmd_reg, cmd_next;
    logic              op_row_reg, op_row_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    dim_t              last_col_reg, last_col_next;
    dim_t              last_row_reg, last_row_next;
    dim_t              cur_row_reg, cur_row_next;
    logic              out_valid_reg, out_valid_next;

    dim_t   left_reg, top_reg, right_reg, bottom_reg;
    color_t color_reg;
    logic   exh_reg;

    dim_t              w, h, ww, wh, mul_a, mul_b, divisor, quot;
    logic [2*DIM_W-1:0] prod_full;
    logic              div_start, div_done;
    logic              out_free, want, out_load;

    bps_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quot)
    );

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.rect_left        = left_reg;
    assign out_ch.rect_top         = top_reg;
    assign out_ch.rect_right       = right_reg;
    assign out_ch.rect_bottom      = bottom_reg;
    assign out_ch.fill_color       = color_reg;
    assign out_ch.budget_exhausted = exh_reg;

    // Edge products: row edge or column edge numerator
    always_comb
    begin
        w         = clamp_dim(cfg.image_width);
        h         = clamp_dim(cfg.image_height);
        ww        = clamp_dim(cfg.window_width);
        wh        = clamp_dim(cfg.window_height);
        mul_a     = op_row_reg ? (h - dim_t'(1) - cmd_reg.next_row)
                               : (w - dim_t'(1) - cmd_reg.col);
        mul_b     = op_row_reg ? wh : ww;
        divisor   = op_row_reg ? h : w;
        prod_full = {{DIM_W{1'b0}}, mul_a} * {{DIM_W{1'b0}}, mul_b};
        out_free  = !out_valid_reg || out_ch.ready;
        want      = cmd_reg.tile
                    || ((quot != last_col_reg) && (cur_row_reg != last_row_reg));
    end

    // Command sequencer
    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        op_row_next   = op_row_reg;
        prod_next     = prod_reg;
        last_col_next = last_col_reg;
        last_row_next = last_row_reg;
        cur_row_next  = cur_row_reg;
        pop           = 1'b0;
        div_start     = 1'b0;
        out_load      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    pop      = 1'b1;
                    cmd_next = q_cmd;
                    if (q_cmd.restart)
                    begin
                        last_row_next = wh;
                        op_row_next   = 1'b1;
                        state_next    = S_MUL;
                    end
                    else if (q_cmd.pixel)
                    begin
                        op_row_next = 1'b0;
                        state_next  = q_cmd.tile ? S_PIX : S_MUL;
                    end
                    else
                    begin
                        last_row_next = cur_row_reg;
                        op_row_next   = 1'b1;
                        state_next    = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                prod_next  = prod_full[PROD_W-1:0];
                state_next = S_START;
            end
            S_START:
            begin
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (op_row_reg)
                    begin
                        cur_row_next  = quot;
                        last_col_next = ww;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_PIX;
                    end
                end
            end
            S_PIX:
            begin
                if (!want || out_free)
                begin
                    if (want)
                    begin
                        out_load = 1'b1;
                        if (!cmd_reg.tile)
                        begin
                            last_col_next = quot;
                        end
                    end
                    if (cmd_reg.row_adv)
                    begin
                        last_row_next = cur_row_reg;
                        op_row_next   = 1'b1;
                        state_next    = S_MUL;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_row_reg    <= 1'b0;
            last_col_reg  <= dim_t'(1);
            last_row_reg  <= dim_t'(1);
            cur_row_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_row_reg    <= op_row_next;
            last_col_reg  <= last_col_next;
            last_row_reg  <= last_row_next;
            cur_row_reg   <= cur_row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Command, product and result payload
    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        prod_reg <= prod_next;
        if (out_load)
        begin
            color_reg <= cmd_reg.color;
            if (cmd_reg.tile)
            begin
                left_reg   <= cmd_reg.col;
                top_reg    <= cmd_reg.tile_y;
                right_reg  <= cmd_reg.col + dim_t'(1);
                bottom_reg <= cmd_reg.tile_y + dim_t'(1);
                exh_reg    <= cmd_reg.spent;
            end
            else
            begin
                left_reg   <= ww - last_col_reg;
                top_reg    <= cur_row_reg;
                right_reg  <= ww - quot;
                bottom_reg <= last_row_reg;
                exh_reg    <= 1'b0;
            end
        end
    end

endmodule

>>> rtl/bmp24_pixel_scaler.sv
// Takes the pixel array of a 24-bit BMP one byte per transfer, packs three
// bytes into a pixel (first byte lowest), skips row padding and emits one fill
// rectangle per drawn pixel. A byte with start_of_image set restarts the image.
// The byte side takes one byte per cycle while the two-entry command queue has
// room. In tile mode a pixel goes from the queue straight to the output stage.
// In scale mode each pixel and each row start pass through a registered 13x13
// multiply, a start state and a 13-step shift-subtract divider that leaves one
// bit of the edge quotient per cycle and flags the end in the cycle after. While
// the divider works the queue fills and the byte side stalls, so over a whole
// scale-mode image the byte rate is set by the divider. Configuration is to be
// written only while the block is idle; the block itself does not enforce this.
module bmp24_pixel_scaler import bps_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [31:0]          cfg_data,
    bps_in_if.sink               in_ch,
    bps_out_if.source            out_ch
);

    bps_cfg_t cfg_reg, cfg_next;
    logic     cmd_push, cmd_full, cmd_pop, cmd_empty;
    bps_cmd_t cmd_data, cmd_head;

    // Configuration register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_DISPLAY_MODE:  cfg_next.display_mode  = cfg_data[0];
                REG_IMAGE_WIDTH:   cfg_next.image_width   = cfg_data[DIM_W-1:0];
                REG_IMAGE_HEIGHT:  cfg_next.image_height  = cfg_data[DIM_W-1:0];
                REG_WINDOW_WIDTH:  cfg_next.window_width  = cfg_data[DIM_W-1:0];
                REG_WINDOW_HEIGHT: cfg_next.window_height = cfg_data[DIM_W-1:0];
                REG_BYTE_BUDGET:   cfg_next.byte_budget   = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.display_mode  <= MODE_TILE;
            cfg_reg.image_width   <= dim_t'(1);
            cfg_reg.image_height  <= dim_t'(1);
            cfg_reg.window_width  <= dim_t'(1);
            cfg_reg.window_height <= dim_t'(1);
            cfg_reg.byte_budget   <= 32'hffff_ffff;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    bps_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_ch    (in_ch),
        .q_full   (cmd_full),
        .push     (cmd_push),
        .push_cmd (cmd_data)
    );

    bps_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (cmd_push),
        .push_cmd (cmd_data),
        .full     (cmd_full),
        .pop      (cmd_pop),
        .pop_cmd  (cmd_head),
        .empty    (cmd_empty)
    );

    bps_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_empty (cmd_empty),
        .q_cmd   (cmd_head),
        .pop     (cmd_pop),
        .out_ch  (out_ch)
    );

    // The front end never queues a command into a full queue
    ast_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> !cmd_full)
        else $error("command queued while queue full");

    // A start byte always queues a restart for the back end
    ast_start_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && in_ch.start_of_image)
            |-> (cmd_push && cmd_data.restart))
        else $error("start of image without restart command");

    // Budget is only flagged on a one-pixel tile fill
    ast_exhausted_tile: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.budget_exhausted)
            |-> (out_ch.rect_right == out_ch.rect_left + dim_t'(1)))
        else $error("budget flag on a fill that is not one column wide");

endmodule

>>> tb/sv/bps_fill_checker.sv
`timescale 1ns / 100ps

// Follows every byte and register write into the scaler, works out the fill
// each byte should give and matches the fills that leave the block in order.
module bps_fill_checker import bps_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [31:0]          cfg_data,
    bps_in_if                    in_ch,
    bps_out_if                   out_ch,
    output int                   fill_errors,
    output int                   fills_pending
);

    typedef struct packed {
        dim_t   left;
        dim_t   top;
        dim_t   right;
        dim_t   bottom;
        color_t color;
        logic   spent;
    } fill_t;

    // Register copies
    logic        mode_r;
    dim_t        img_w_r;
    dim_t        img_h_r;
    dim_t        win_w_r;
    dim_t        win_h_r;
    logic [31:0] budget_r;

    // Position in the pixel array
    logic [1:0]  byte_slot;
    logic [15:0] low_bytes;
    dim_t        col_idx;
    dim_t        row_idx;
    logic [1:0]  pad_left;
    dim_t        prev_col_edge;
    dim_t        prev_row_edge;
    dim_t        row_edge;
    longint      budget_left;
    bit          image_done;

    fill_t expected_fills[$];

    // Zero counts as one, anything above the bound as the bound
    function automatic int unsigned eff_dim(dim_t v);
        if (v == '0)
        begin
            return 1;
        end
        if (v > dim_t'(MAX_DIM))
        begin
            return MAX_DIM;
        end
        return v;
    endfunction

    // Window edges for the row now starting; rows arrive bottom-up
    function automatic void open_row();
        int unsigned h;
        int unsigned r;
        h = eff_dim(img_h_r);
        r = (row_idx < h) ? row_idx : h - 1;
        prev_col_edge = dim_t'(eff_dim(win_w_r));
        row_edge = dim_t'(((h - 1 - r) * eff_dim(win_h_r)) / h);
    endfunction

    function automatic void close_row();
        prev_row_edge = row_edge;
        row_idx = row_idx + 1'b1;
        col_idx = '0;
        pad_left = '0;
        if (row_idx >= eff_dim(img_h_r))
        begin
            image_done = 1'b1;
        end
        else
        begin
            open_row();
        end
    endfunction

    function automatic void new_image();
        byte_slot = '0;
        low_bytes = '0;
        col_idx = '0;
        row_idx = '0;
        pad_left = '0;
        prev_row_edge = dim_t'(eff_dim(win_h_r));
        budget_left = {32'b0, budget_r};
        image_done = 1'b0;
        open_row();
    endfunction

    function automatic void power_on();
        mode_r = MODE_TILE;
        img_w_r = dim_t'(1);
        img_h_r = dim_t'(1);
        win_w_r = dim_t'(1);
        win_h_r = dim_t'(1);
        budget_r = 32'hffff_ffff;
        byte_slot = '0;
        low_bytes = '0;
        col_idx = '0;
        row_idx = '0;
        pad_left = '0;
        prev_col_edge = dim_t'(1);
        prev_row_edge = dim_t'(1);
        row_edge = '0;
        budget_left = {32'b0, budget_r};
        image_done = 1'b0;
    endfunction

    // One byte of the pixel array; returns 1 when it completes a drawn pixel
    function automatic bit take_byte(input logic [7:0] b, input logic sof, output fill_t f);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned y;
        int unsigned ww;
        int unsigned e;
        bit          made;
        f = '0;
        made = 1'b0;
        if (sof)
        begin
            new_image();
        end
        if (image_done)
        begin
            return 1'b0;
        end
        w = eff_dim(img_w_r);
        h = eff_dim(img_h_r);
        if (row_idx >= h)
        begin
            image_done = 1'b1;
            return 1'b0;
        end
        // row padding
        if (pad_left != '0)
        begin
            pad_left = pad_left - 1'b1;
            if (pad_left == '0)
            begin
                close_row();
            end
            return 1'b0;
        end
        // pack three bytes, first one lowest
        if (byte_slot == 2'd0)
        begin
            low_bytes = {8'h00, b};
            byte_slot = 2'd1;
            return 1'b0;
        end
        if (byte_slot == 2'd1)
        begin
            low_bytes[15:8] = b;
            byte_slot = 2'd2;
            return 1'b0;
        end
        byte_slot = 2'd0;
        f.color = {b, low_bytes};
        c = (col_idx < w) ? col_idx : w - 1;
        if (mode_r == MODE_TILE)
        begin
            y = h - 1 - row_idx;
            budget_left = budget_left - 3;
            f.left = dim_t'(c);
            f.top = dim_t'(y);
            f.right = dim_t'(c + 1);
            f.bottom = dim_t'(y + 1);
            f.spent = (budget_left <= 0);
            if (f.spent)
            begin
                image_done = 1'b1;
                return 1'b1;
            end
            made = 1'b1;
        end
        else
        begin
            // nearest neighbour: drop the pixel when its rectangle collapses
            ww = eff_dim(win_w_r);
            e = ((w - 1 - c) * ww) / w;
            if (e != int'(prev_col_edge) && row_edge != prev_row_edge)
            begin
                f.left = dim_t'(ww - prev_col_edge);
                f.top = row_edge;
                f.right = dim_t'(ww - e);
                f.bottom = prev_row_edge;
                f.spent = 1'b0;
                made = 1'b1;
                prev_col_edge = dim_t'(e);
            end
        end
        col_idx = col_idx + 1'b1;
        if (col_idx >= w)
        begin
            pad_left = 2'(w & 3);
            if (pad_left == '0)
            begin
                close_row();
            end
        end
        return made;
    endfunction

    function automatic int field_differs(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s expected 0x%0h got 0x%0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk)
    begin
        int    bad;
        fill_t got;
        fill_t want;
        fill_t next_fill;
        if (!rst_n)
        begin
            power_on();
            expected_fills.delete();
            fill_errors <= 0;
            fills_pending <= 0;
        end
        else
        begin
            bad = 0;
            // output transfer first: a byte taken at this edge cannot be out yet
            if (out_ch.valid && out_ch.ready)
            begin
                got = {out_ch.rect_left, out_ch.rect_top, out_ch.rect_right,
                       out_ch.rect_bottom, out_ch.fill_color, out_ch.budget_exhausted};
                if (expected_fills.size() == 0)
                begin
                    $error("unexpected fill (%0d,%0d)-(%0d,%0d) colour 0x%0h",
                           got.left, got.top, got.right, got.bottom, got.color);
                    bad++;
                end
                else
                begin
                    want = expected_fills.pop_front();
                    bad += field_differs("rect_left", want.left, got.left);
                    bad += field_differs("rect_top", want.top, got.top);
                    bad += field_differs("rect_right", want.right, got.right);
                    bad += field_differs("rect_bottom", want.bottom, got.bottom);
                    bad += field_differs("fill_color", want.color, got.color);
                    bad += field_differs("budget_exhausted", want.spent, got.spent);
                end
            end
            // register writes
            if (cfg_we)
            begin
                case (cfg_idx)
                    REG_DISPLAY_MODE:  mode_r = cfg_data[0];
                    REG_IMAGE_WIDTH:   img_w_r = cfg_data[DIM_W-1:0];
                    REG_IMAGE_HEIGHT:  img_h_r = cfg_data[DIM_W-1:0];
                    REG_WINDOW_WIDTH:  win_w_r = cfg_data[DIM_W-1:0];
                    REG_WINDOW_HEIGHT: win_h_r = cfg_data[DIM_W-1:0];
                    REG_BYTE_BUDGET:   budget_r = cfg_data;
                    default: ;
                endcase
            end
            // byte transfer
            if (in_ch.valid && in_ch.ready)
            begin
                if (take_byte(in_ch.pixel_byte, in_ch.start_of_image, next_fill))
                begin
                    expected_fills.push_back(next_fill);
                end
            end
            fill_errors <= fill_errors + bad;
            fills_pending <= expected_fills.size();
        end
    end

endmodule

>>> tb/sv/bmp24_pixel_scaler_tb.sv
`timescale 1ns / 100ps

module bmp24_pixel_scaler_tb;
    import bps_pkg::*;

    typedef enum int {IDLE_NONE, IDLE_SOURCE, IDLE_SINK, IDLE_BOTH} idling_t;

    localparam int          SETTLE_CYCLES = 80;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          RANDOM_BYTES  = 950;
    localparam int          MAX_GAP       = 40;
    localparam int          DIM_ALL_ONES  = 8191;
    localparam logic [31:0] BUDGET_MAX    = 32'hffff_ffff;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [31:0]          cfg_data;

    int fill_errors;
    int fills_pending;
    int src_idle_pct;
    int snk_stall_pct;
    bit hold_req;
    bit hold_taken;
    int hold_left;
    int bytes_sent;

    bps_in_if  pixel_in ();
    bps_out_if fill_out ();

    bmp24_pixel_scaler uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .in_ch    (pixel_in),
        .out_ch   (fill_out)
    );

    bps_fill_checker fill_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_idx       (cfg_idx),
        .cfg_data      (cfg_data),
        .in_ch         (pixel_in),
        .out_ch        (fill_out),
        .fill_errors   (fill_errors),
        .fills_pending (fills_pending)
    );

    always #5 clk = ~clk;

    // Long hold-off on the fill side, counted once on request
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_taken <= 1'b0;
        end
        else if (hold_req && !hold_taken)
        begin
            hold_taken <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Fill side: random stalls, held off while the hold-off runs
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            fill_out.ready <= 1'b0;
        end
        else if ((hold_req && !hold_taken) || (hold_left != 0))
        begin
            fill_out.ready <= 1'b0;
        end
        else
        begin
            fill_out.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
        end
    end

    // Run limit
    initial
    begin
        #5_000_000;
        $display("bmp24_pixel_scaler verification failed");
        $finish;
    end

    task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= value;
        @(posedge clk);
    endtask

    // Writes the registers whose index bit is set in pick
    task automatic load_regs(logic mode, int iw, int ih, int ww, int wh,
                             logic [31:0] budget, logic [5:0] pick);
        if (pick[REG_DISPLAY_MODE])
        begin
            put_reg(REG_DISPLAY_MODE, {31'b0, mode});
        end
        if (pick[REG_IMAGE_WIDTH])
        begin
            put_reg(REG_IMAGE_WIDTH, 32'(iw));
        end
        if (pick[REG_IMAGE_HEIGHT])
        begin
            put_reg(REG_IMAGE_HEIGHT, 32'(ih));
        end
        if (pick[REG_WINDOW_WIDTH])
        begin
            put_reg(REG_WINDOW_WIDTH, 32'(ww));
        end
        if (pick[REG_WINDOW_HEIGHT])
        begin
            put_reg(REG_WINDOW_HEIGHT, 32'(wh));
        end
        if (pick[REG_BYTE_BUDGET])
        begin
            put_reg(REG_BYTE_BUDGET, budget);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic set_idling(idling_t k);
        case (k)
            IDLE_SOURCE:
            begin
                src_idle_pct = 81;
                snk_stall_pct <= 0;
            end
            IDLE_SINK:
            begin
                src_idle_pct = 0;
                snk_stall_pct <= 81;
            end
            IDLE_BOTH:
            begin
                src_idle_pct = 32;
                snk_stall_pct <= 32;
            end
            default:
            begin
                src_idle_pct = 0;
                snk_stall_pct <= 0;
            end
        endcase
    endtask

    // One byte transfer, after a random gap with valid low
    task automatic send_byte(logic [7:0] b, logic sof);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < src_idle_pct)
        begin
            gap++;
        end
        if (gap != 0)
        begin
            pixel_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_in.valid <= 1'b1;
        pixel_in.pixel_byte <= b;
        pixel_in.start_of_image <= sof;
        do
        begin
            @(posedge clk);
        end
        while (!pixel_in.ready);
        bytes_sent++;
    endtask

    // A pixel array of random bytes sized from the register values, cut at cap
    task automatic send_image(int iw, int ih, bit sof_first, int extra, int cap,
                              int sof_permille);
        int w;
        int h;
        int total;
        w = (iw == 0) ? 1 : ((iw > MAX_DIM) ? MAX_DIM : iw);
        h = (ih == 0) ? 1 : ((ih > MAX_DIM) ? MAX_DIM : ih);
        total = (w * 3 + w % 4) * h + extra;
        if (total > cap)
        begin
            total = cap;
        end
        for (int i = 0; i < total; i++)
        begin
            send_byte(8'($urandom_range(0, 255)),
                      (i == 0 && sof_first) || ($urandom_range(0, 999) < sof_permille));
        end
    endtask

    // Block idle again: every fill out and any dropped pixel worked off
    task automatic drain_fills();
        pixel_in.valid <= 1'b0;
        @(posedge clk);
        while (fills_pending != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic int odd_dim();
        case ($urandom_range(0, 4))
            0: return 0;
            1: return 1;
            2: return MAX_DIM;
            3: return DIM_ALL_ONES;
            default: return $urandom_range(0, DIM_ALL_ONES);
        endcase
    endfunction

    function automatic logic [31:0] odd_budget();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return BUDGET_MAX;
            2: return $urandom_range(0, 90);
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int          warmup;
        int          phase_no;
        int          kind;
        int          iw;
        int          ih;
        int          ww;
        int          wh;
        logic [31:0] budget;

        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_idx <= '0;
        cfg_data <= '0;
        pixel_in.valid <= 1'b0;
        pixel_in.pixel_byte <= '0;
        pixel_in.start_of_image <= 1'b0;
        hold_req <= 1'b0;
        src_idle_pct = 0;
        snk_stall_pct <= 0;
        bytes_sent = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_idling(IDLE_NONE);

        // Out of reset, no start marker: 1x1 tile image, its padding byte, then a byte past its end
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7f, 1'b0);
        send_byte(8'h01, 1'b0);
        drain_fills();

        // Zero width and over-range height; budget of two pixels runs out
        load_regs(MODE_TILE, 0, DIM_ALL_ONES, 1, 1, 32'd6, 6'h3f);
        send_byte(8'hff, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'haa, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(8'h56, 1'b0);
        send_byte(8'h9c, 1'b0);
        drain_fills();

        // Scale to the largest window, then shrink the window mid-image
        load_regs(MODE_SCALE, 1, 4, MAX_DIM, MAX_DIM, BUDGET_MAX, 6'h3f);
        send_byte(8'h0f, 1'b1);
        send_byte(8'hf0, 1'b0);
        send_byte(8'hc3, 1'b0);
        send_byte(8'h3c, 1'b0);
        drain_fills();
        load_regs(MODE_SCALE, 1, 4, 0, 3, BUDGET_MAX, 6'b011000);
        send_byte(8'h81, 1'b0);
        send_byte(8'h42, 1'b0);
        send_byte(8'h24, 1'b0);
        send_byte(8'h18, 1'b0);
        drain_fills();

        // Long hold-off on the fill side while bytes keep coming
        hold_req <= 1'b1;
        load_regs(MODE_TILE, 5, 4, 1, 1, BUDGET_MAX, 6'h3f);
        send_image(5, 4, 1'b1, 0, 400, 0);
        drain_fills();

        warmup = bytes_sent;
        phase_no = 0;
        while (bytes_sent < warmup + RANDOM_BYTES)
        begin
            set_idling(idling_t'(phase_no % 4));
            phase_no++;
            kind = $urandom_range(0, 99);
            if (kind < 65)
            begin
                // small well-formed image
                iw = $urandom_range(1, 6);
                ih = $urandom_range(1, 5);
                ww = $urandom_range(1, 24);
                wh = $urandom_range(1, 24);
                budget = ($urandom_range(0, 4) == 0) ? 32'($urandom_range(0, 60)) : BUDGET_MAX;
                load_regs(1'($urandom_range(0, 1)), iw, ih, ww, wh, budget, 6'h3f);
                send_image(iw, ih, 1'b1, $urandom_range(0, 3), 400, 0);
            end
            else if (kind < 80)
            begin
                // extreme sizes and budgets, stream cut short
                iw = odd_dim();
                ih = odd_dim();
                ww = odd_dim();
                wh = odd_dim();
                load_regs(1'($urandom_range(0, 1)), iw, ih, ww, wh, odd_budget(), 6'h3f);
                send_image(iw, ih, 1'b1, 0, $urandom_range(8, 48), 0);
            end
            else if (kind < 90)
            begin
                // some registers changed, image carries on without a restart
                iw = $urandom_range(0, 8);
                ih = $urandom_range(0, 8);
                ww = $urandom_range(0, 30);
                wh = $urandom_range(0, 30);
                load_regs(1'($urandom_range(0, 1)), iw, ih, ww, wh, odd_budget(),
                          6'($urandom_range(1, 63)));
                send_image(iw, ih, 1'b0, 0, $urandom_range(6, 30), 0);
            end
            else
            begin
                // stray start markers inside the stream
                iw = $urandom_range(1, 7);
                ih = $urandom_range(1, 4);
                ww = $urandom_range(1, 16);
                wh = $urandom_range(1, 16);
                load_regs(1'($urandom_range(0, 1)), iw, ih, ww, wh, BUDGET_MAX, 6'h3f);
                send_image(iw, ih, 1'b1, 2, 60, 40);
            end
            drain_fills();
        end

        if (fill_errors == 0 && fills_pending == 0)
        begin
            $display("bmp24_pixel_scaler verification clean");
        end
        else
        begin
            $display("bmp24_pixel_scaler verification failed");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/bps_pkg.sv
rtl/bps_if.sv
rtl/bps_front.sv
rtl/bps_cmd_fifo.sv
rtl/bps_divider.sv
rtl/bps_back.sv
rtl/bmp24_pixel_scaler.sv
tb/sv/bps_fill_checker.sv
tb/sv/bmp24_pixel_scaler_tb.sv
